### hw/rtl/sdspi_pkg.sv
// Shared types, codes and constants for the SD SPI command/response engine.
package sdspi_pkg;

    localparam int unsigned REG_DATA_BYTES = 16;
    localparam int unsigned EXTRA_BYTES    = 4;
    localparam int unsigned CRC_BYTES      = 2;
    localparam int unsigned FRAME_BYTES    = 6;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN = 8'hFE;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    localparam logic CFG_POLL_LIMIT  = 1'b0;
    localparam logic CFG_TOKEN_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_POLL  = 3'd1,
        PH_EXTRA = 3'd2,
        PH_BUSY  = 3'd3,
        PH_TOKEN = 3'd4,
        PH_DATA  = 3'd5,
        PH_CRC   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        RSP_R1  = 2'd0,
        RSP_R1B = 2'd1,
        RSP_R2  = 2'd2,
        RSP_R3  = 2'd3
    } t_rsp;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_RSP  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RSP_ERR = 2'd2;

    typedef struct packed {
        logic       command;
        logic [7:0] cmd_byte;
        logic [31:0] argument;
        logic [7:0] crc_byte;
        logic [1:0] response_type;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic                          load;
        logic [2:0]                    count;
        t_result [FRAME_BYTES-1:0]     res;
    } t_batch;

    function automatic t_result mk_res(input logic [1:0] kind, input logic [7:0] data_byte,
                                       input logic [1:0] status, input logic last);
        t_result r;
        r.kind      = kind;
        r.data_byte = data_byte;
        r.status    = status;
        r.last      = last;
        return r;
    endfunction

endpackage

### hw/rtl/sdspi_seq.sv
// Exchange sequencer: phase state and the results of one item.
module sdspi_seq import sdspi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_item      i_item,
    input  logic [7:0] i_poll_limit,
    input  logic [7:0] i_token_limit,
    output t_batch     o_batch
);

    t_phase     r_phase, n_phase;
    t_rsp       r_type, n_type;
    logic [7:0] r_poll_cnt, n_poll_cnt;
    logic [4:0] r_byte_cnt, n_byte_cnt;

    logic [7:0] poll_inc;
    logic [4:0] byte_inc;
    logic [7:0] poll_eff;
    logic [7:0] token_eff;

    assign poll_inc  = r_poll_cnt + 8'd1;
    assign byte_inc  = r_byte_cnt + 5'd1;
    assign poll_eff  = (i_poll_limit == 8'd0) ? 8'd1 : i_poll_limit;
    assign token_eff = (i_token_limit == 8'd0) ? 8'd1 : i_token_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_type     <= RSP_R1;
            r_poll_cnt <= 8'd0;
            r_byte_cnt <= 5'd0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_poll_cnt <= n_poll_cnt;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    always_comb begin
        logic [7:0] b;
        b = i_item.rx_byte;
        n_phase    = r_phase;
        n_type     = r_type;
        n_poll_cnt = r_poll_cnt;
        n_byte_cnt = r_byte_cnt;
        o_batch.load  = i_advance;
        o_batch.count = 3'd0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            o_batch.res[k] = mk_res(KIND_TX, BYTE_ZERO, ST_OK, 1'b0);
        end
        if (i_item.command == CMD_START) begin
            o_batch.count  = 3'(FRAME_BYTES);
            o_batch.res[0] = mk_res(KIND_TX, i_item.cmd_byte, ST_OK, 1'b0);
            o_batch.res[1] = mk_res(KIND_TX, i_item.argument[31:24], ST_OK, 1'b0);
            o_batch.res[2] = mk_res(KIND_TX, i_item.argument[23:16], ST_OK, 1'b0);
            o_batch.res[3] = mk_res(KIND_TX, i_item.argument[15:8], ST_OK, 1'b0);
            o_batch.res[4] = mk_res(KIND_TX, i_item.argument[7:0], ST_OK, 1'b0);
            o_batch.res[5] = mk_res(KIND_TX, i_item.crc_byte, ST_OK, 1'b1);
            n_type     = t_rsp'(i_item.response_type);
            n_phase    = PH_POLL;
            n_poll_cnt = 8'd0;
            n_byte_cnt = 5'd0;
        end else begin
            unique case (r_phase)
                PH_POLL: begin
                    if (b == BYTE_IDLE) begin
                        n_poll_cnt = poll_inc;
                        if (poll_inc >= poll_eff) begin
                            o_batch.count  = 3'd1;
                            o_batch.res[0] = mk_res(KIND_DONE, BYTE_ZERO, ST_TIMEOUT, 1'b1);
                            n_phase        = PH_IDLE;
                        end
                    end else begin
                        unique case (r_type)
                            RSP_R1: begin
                                o_batch.count  = 3'd1;
                                o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b1);
                                n_phase        = PH_IDLE;
                            end
                            RSP_R3: begin
                                o_batch.count  = 3'd1;
                                o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b0);
                                n_phase        = PH_EXTRA;
                                n_byte_cnt     = 5'd0;
                            end
                            RSP_R1B: begin
                                o_batch.count  = 3'd1;
                                o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b0);
                                n_phase        = PH_BUSY;
                            end
                            default: begin
                                if (b != BYTE_ZERO) begin
                                    o_batch.count  = 3'd1;
                                    o_batch.res[0] = mk_res(KIND_RSP, b, ST_RSP_ERR, 1'b1);
                                    n_phase        = PH_IDLE;
                                end else begin
                                    n_phase    = PH_TOKEN;
                                    n_poll_cnt = 8'd0;
                                end
                            end
                        endcase
                    end
                end
                PH_EXTRA: begin
                    n_byte_cnt     = byte_inc;
                    o_batch.count  = 3'd1;
                    if (byte_inc >= 5'(EXTRA_BYTES)) begin
                        o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b1);
                        n_phase        = PH_IDLE;
                    end else begin
                        o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b0);
                    end
                end
                PH_BUSY: begin
                    if (b == BYTE_IDLE) begin
                        o_batch.count  = 3'd1;
                        o_batch.res[0] = mk_res(KIND_DONE, BYTE_ZERO, ST_OK, 1'b1);
                        n_phase        = PH_IDLE;
                    end
                end
                PH_TOKEN: begin
                    if (b == BYTE_TOKEN) begin
                        n_phase    = PH_DATA;
                        n_byte_cnt = 5'd0;
                    end else begin
                        n_poll_cnt = poll_inc;
                        if (poll_inc >= token_eff) begin
                            o_batch.count  = 3'd1;
                            o_batch.res[0] = mk_res(KIND_DONE, BYTE_ZERO, ST_TIMEOUT, 1'b1);
                            n_phase        = PH_IDLE;
                        end
                    end
                end
                PH_DATA: begin
                    o_batch.count = 3'd1;
                    if (byte_inc >= 5'(REG_DATA_BYTES)) begin
                        o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b1);
                        n_phase        = PH_CRC;
                        n_byte_cnt     = 5'd0;
                    end else begin
                        o_batch.res[0] = mk_res(KIND_RSP, b, ST_OK, 1'b0);
                        n_byte_cnt     = byte_inc;
                    end
                end
                PH_CRC: begin
                    n_byte_cnt = byte_inc;
                    if (byte_inc >= 5'(CRC_BYTES)) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/sdspi_out.sv
// Result buffer: holds up to one frame of results and sends one per transfer.
module sdspi_out import sdspi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_batch     i_batch,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic [2:0]                r_cnt, n_cnt;
    t_result [FRAME_BYTES-1:0] r_ent, n_ent;
    logic                      xfer;

    assign o_valid     = (r_cnt != 3'd0);
    assign xfer        = o_valid && !i_stall;
    assign o_free      = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && xfer);
    assign o_kind      = r_ent[0].kind;
    assign o_data_byte = r_ent[0].data_byte;
    assign o_status    = r_ent[0].status;
    assign o_last      = r_ent[0].last;

    always_comb begin
        n_cnt = r_cnt;
        n_ent = r_ent;
        if (i_batch.load) begin
            n_cnt = i_batch.count;
            n_ent = i_batch.res;
        end else if (xfer) begin
            n_cnt = r_cnt - 3'd1;
            for (int k = 0; k < FRAME_BYTES - 1; k++) begin
                n_ent[k] = r_ent[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

### hw/rtl/sd_spi_command_response_engine.sv
// Top level of the SD SPI command/response engine.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  input    | i_valid / o_stall  | i_command i_cmd_byte i_argument i_crc_byte
//           |                    | i_response_type i_rx_byte
//  output   | o_valid / i_stall  | o_kind o_data_byte o_status o_last
//  config   | i_cfg_we           | i_cfg_index i_cfg_data
//
// An item is registered, then its results are computed and loaded into the result
// buffer as soon as the buffer is free to take them.
// One byte item per cycle while the output takes its results.
// A start item holds the input side while its frame leaves the result buffer one byte
// per output transfer. Output stalls back up into o_stall.
// Synchronous active-low reset: engine idle, limits 255, buffers empty.
module sd_spi_command_response_engine import sdspi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_cmd_byte,
    input  logic [31:0] i_argument,
    input  logic [7:0]  i_crc_byte,
    input  logic [1:0]  i_response_type,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_poll_limit;
    logic [7:0] r_token_limit;
    logic       r_in_valid;
    t_item      r_item;
    logic       buf_free;
    logic       advance;
    logic       in_xfer;
    t_batch     batch;

    assign advance = r_in_valid && buf_free;
    assign o_stall = r_in_valid && !buf_free;
    assign in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit  <= 8'd255;
            r_token_limit <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLL_LIMIT:  r_poll_limit  <= i_cfg_data;
                CFG_TOKEN_LIMIT: r_token_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.command       <= i_command;
            r_item.cmd_byte      <= i_cmd_byte;
            r_item.argument      <= i_argument;
            r_item.crc_byte      <= i_crc_byte;
            r_item.response_type <= i_response_type;
            r_item.rx_byte       <= i_rx_byte;
        end
    end

    sdspi_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_item        (r_item),
        .i_poll_limit  (r_poll_limit),
        .i_token_limit (r_token_limit),
        .o_batch       (batch)
    );

    sdspi_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_batch     (batch),
        .o_free      (buf_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs busy after reset");
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DONE |-> o_data_byte == BYTE_ZERO && o_last)
        else $error("completion result carries data or is not last");
    a_tx_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_TX |-> o_status == ST_OK)
        else $error("transmit byte with nonzero status");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && o_valid)
        else $error("input stalled with empty stages");
`endif

endmodule
